[rtl/lts_pkg.sv]
// Shared types, constants and helpers for the tile line stepper.
package lts_pkg;

	localparam int COORD_W         = 6;
	localparam int ERR_W           = COORD_W + 2;
	localparam int MAP_TILES_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COORD_W:0]   delta2_t;

	// One line, already normalized so that rows never decrease.
	typedef struct packed {
		coord_t  x;
		coord_t  y;
		delta2_t dx2;
		delta2_t dy2;
		logic    x_neg;
		logic    y_major;
		coord_t  major;
	} cmd_t;

	function automatic coord_t clamp_coord(input coord_t v, input coord_t lim);
		return (v > lim) ? lim : v;
	endfunction

endpackage

[rtl/lts_front.sv]
// Front end: accepts line requests, clamps and orders the endpoints, classifies the line.
module lts_front #(
	parameter int MAP_TILES = lts_pkg::MAP_TILES_DEF
) (
	input  logic            in_valid,
	output logic            in_ready,
	input  lts_pkg::coord_t start_x,
	input  lts_pkg::coord_t start_y,
	input  lts_pkg::coord_t end_x,
	input  lts_pkg::coord_t end_y,
	input  logic            q_full,
	output logic            push,
	output lts_pkg::cmd_t   cmd
);

	localparam lts_pkg::coord_t LIM = lts_pkg::coord_t'(MAP_TILES - 1);

	lts_pkg::coord_t x1, y1, x2, y2, sx, sy, ex, ey, adx, ady;
	logic            x_neg, zero_len;

	always_comb begin
		sx = lts_pkg::clamp_coord(start_x, LIM);
		sy = lts_pkg::clamp_coord(start_y, LIM);
		ex = lts_pkg::clamp_coord(end_x, LIM);
		ey = lts_pkg::clamp_coord(end_y, LIM);
		// Upward lines are drawn from the lower row.
		if (sy > ey) begin
			x1 = ex;
			y1 = ey;
			x2 = sx;
			y2 = sy;
		end else begin
			x1 = sx;
			y1 = sy;
			x2 = ex;
			y2 = ey;
		end
		x_neg    = x2 < x1;
		adx      = x_neg ? (x1 - x2) : (x2 - x1);
		ady      = y2 - y1;
		zero_len = (adx == '0) && (ady == '0);

		// Horizontal, vertical and diagonal lines fall out of the same error
		// stepper: a zero minor delta never steps the minor axis, and equal
		// deltas step it every time.
		cmd.x       = x1;
		cmd.y       = y1;
		cmd.dx2     = {adx, 1'b0};
		cmd.dy2     = {ady, 1'b0};
		cmd.x_neg   = x_neg;
		cmd.y_major = adx < ady;
		cmd.major   = (adx < ady) ? ady : adx;
	end

	assign in_ready = !q_full;
	// A line with equal endpoints is taken and dropped.
	assign push     = in_valid && !q_full && !zero_len;

endmodule

[rtl/lts_fifo.sv]
// Short command queue between the front end and the stepper.
module lts_fifo #(
	parameter int DEPTH = lts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lts_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          deq_valid,
	output lts_pkg::cmd_t rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lts_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign deq_valid = count_q != '0;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> deq_valid)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

[rtl/lts_back.sv]
// Back end: error-term stepper that walks one line, one tile per cycle unless the output stalls.
module lts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            deq_valid,
	input  lts_pkg::cmd_t   cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output lts_pkg::coord_t tile_x,
	output lts_pkg::coord_t tile_y,
	output logic            last_tile
);

	localparam int ERR_W = lts_pkg::ERR_W;

	logic                    busy_q;
	lts_pkg::coord_t         x_q, y_q, remain_q;
	logic signed [ERR_W-1:0] err_q;
	lts_pkg::delta2_t        dx2_q, dy2_q;
	logic                    x_neg_q, y_major_q;

	logic                    out_valid_q, last_q;
	lts_pkg::coord_t         tile_x_q, tile_y_q;

	logic                    emit, last_now, minor_step, x_step, y_step;
	logic signed [ERR_W-1:0] minor2_s, major2_s, e_sub, e_next;
	lts_pkg::coord_t         nx, ny;

	assign emit     = busy_q && (!out_valid_q || out_ready);
	assign last_now = remain_q == '0;
	assign pop      = deq_valid && (!busy_q || (emit && last_now));

	always_comb begin
		minor2_s   = signed'(ERR_W'(y_major_q ? dx2_q : dy2_q));
		major2_s   = signed'(ERR_W'(y_major_q ? dy2_q : dx2_q));
		e_sub      = err_q - minor2_s;
		minor_step = e_sub[ERR_W-1];
		e_next     = minor_step ? (e_sub + major2_s) : e_sub;
		x_step     = y_major_q ? minor_step : 1'b1;
		y_step     = y_major_q ? 1'b1 : minor_step;
		nx         = x_step ? (x_neg_q ? (x_q - 1'b1) : (x_q + 1'b1)) : x_q;
		ny         = y_step ? (y_q + 1'b1) : y_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q       <= cmd.x;
			y_q       <= cmd.y;
			err_q     <= signed'(ERR_W'(cmd.major) - ERR_W'(1));
			remain_q  <= cmd.major;
			dx2_q     <= cmd.dx2;
			dy2_q     <= cmd.dy2;
			x_neg_q   <= cmd.x_neg;
			y_major_q <= cmd.y_major;
		end else if (emit) begin
			x_q      <= nx;
			y_q      <= ny;
			err_q    <= e_next;
			remain_q <= remain_q - 1'b1;
		end
		if (emit) begin
			tile_x_q <= x_q;
			tile_y_q <= y_q;
			last_q   <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && last_now) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tile_x    = tile_x_q;
	assign tile_y    = tile_y_q;
	assign last_tile = last_q;

	a_stay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !last_now |=> busy_q)
		else $error("stepper stopped before the last tile");

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last_now && !pop |=> !busy_q)
		else $error("stepper still busy after the last tile");

	a_no_pop_midline: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !last_now |-> !pop)
		else $error("new line loaded in the middle of a line");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> last_tile == $past(last_now))
		else $error("last tile flag does not match the remaining count");

endmodule

[rtl/tile_line_stepper_unit.sv]
// Top level of the tile line stepper: front end, command queue and stepper.
// An accepted request passes the command queue, the stepper registers and the output register.
// Throughput: one tile per cycle while the output is not stalled; a line whose longer delta is m
// yields m+1 tiles, at most MAP_TILES, set by the single stepper that walks the error term.
// A request with equal endpoints is accepted but produces no tile.
// Reset (arst_n low) empties the queue, idles the stepper and drops any pending tile.
module tile_line_stepper_unit #(
	parameter int MAP_TILES   = lts_pkg::MAP_TILES_DEF,
	parameter int QUEUE_DEPTH = lts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lts_pkg::coord_t start_x,
	input  lts_pkg::coord_t start_y,
	input  lts_pkg::coord_t end_x,
	input  lts_pkg::coord_t end_y,
	output logic            out_valid,
	input  logic            out_ready,
	output lts_pkg::coord_t tile_x,
	output lts_pkg::coord_t tile_y,
	output logic            last_tile
);

	// The front end clamps the coordinates to the map, swaps the endpoints so
	// that rows never decrease, and reduces each request to a start tile, the
	// doubled deltas, the x direction and the major axis.
	logic          q_full, push, pop, deq_valid;
	lts_pkg::cmd_t wr_cmd, rd_cmd;

	lts_front #(
		.MAP_TILES(MAP_TILES)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.q_full   (q_full),
		.push     (push),
		.cmd      (wr_cmd)
	);

	// The queue lets the front end take new requests while the stepper is
	// still walking an earlier line or the output is stalled.
	lts_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (wr_cmd),
		.full      (q_full),
		.pop       (pop),
		.deq_valid (deq_valid),
		.rdata     (rd_cmd)
	);

	// The stepper loads the next line in the same cycle that it hands out the
	// last tile of the current one, so consecutive lines leave no gap.
	lts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (deq_valid),
		.cmd       (rd_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tile_x    (tile_x),
		.tile_y    (tile_y),
		.last_tile (last_tile)
	);

endmodule
